// ===== design/erff_pkg.sv =====
// ----------------------------------------------------------------------------
// erff_pkg
// Shared types, constants and helpers for the receive frame filter.
// ----------------------------------------------------------------------------
package erff_pkg;

    // default width of the byte counter and the reported length
    localparam int LENGTH_BITS_DEFAULT = 16;

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 48;
    localparam int MAC_BITS       = 48;
    localparam int IP_BITS        = 32;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_STATION_MAC = 2'd0,
        CFG_STATION_IP  = 2'd1
    } cfg_reg_t;

    // ethertypes and minimum lengths
    localparam logic [15:0] ETH_IPV4   = 16'h0800;
    localparam logic [15:0] ETH_ARP    = 16'h0806;
    localparam logic [7:0]  BCAST_BYTE = 8'hff;
    localparam int MIN_FRAME = 14;
    localparam int MIN_IPV4  = 34;
    localparam int MIN_ARP   = 42;

    // byte positions inside the frame
    localparam int POS_SRC_MAC   = 6;
    localparam int POS_TYPE_HI   = 12;
    localparam int POS_TYPE_LO   = 13;
    localparam int POS_IPV4_SRC  = 26;
    localparam int POS_ARP_SPA   = 28;
    localparam int POS_IPV4_DST  = 30;
    localparam int POS_IPV4_END  = 34;
    localparam int POS_ARP_END   = 32;

    // per-frame match state
    typedef struct packed {
        logic [15:0] ether_type;
        logic        dest_is_station;
        logic        dest_is_broadcast;
        logic        source_is_station;
        logic        ipv4_source_match;
        logic        ipv4_dest_match;
        logic        arp_sender_match;
    } frame_info_t;

    localparam frame_info_t FRAME_INFO_CLEAR = '{
        ether_type:        16'h0000,
        dest_is_station:   1'b1,
        dest_is_broadcast: 1'b1,
        source_is_station: 1'b1,
        ipv4_source_match: 1'b1,
        ipv4_dest_match:   1'b1,
        arp_sender_match:  1'b1
    };

    // octet k of the station mac, k = 0 is the first wire byte
    function automatic logic [7:0] mac_octet(input logic [MAC_BITS-1:0] mac,
                                             input logic [2:0] k);
        logic [7:0] octet;
        unique case (k)
            3'd0:    octet = mac[47:40];
            3'd1:    octet = mac[39:32];
            3'd2:    octet = mac[31:24];
            3'd3:    octet = mac[23:16];
            3'd4:    octet = mac[15:8];
            3'd5:    octet = mac[7:0];
            default: octet = 8'h00;
        endcase
        return octet;
    endfunction

    // octet k of the station ip, k = 0 is the first wire byte
    function automatic logic [7:0] ip_octet(input logic [IP_BITS-1:0] ip,
                                            input logic [1:0] k);
        logic [7:0] octet;
        unique case (k)
            2'd0:    octet = ip[31:24];
            2'd1:    octet = ip[23:16];
            2'd2:    octet = ip[15:8];
            default: octet = ip[7:0];
        endcase
        return octet;
    endfunction

endpackage

// ===== design/erff_cfg.sv =====
// ----------------------------------------------------------------------------
// erff_cfg
// Station address registers, written over the configuration port.
// ----------------------------------------------------------------------------
module erff_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [erff_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  logic [erff_pkg::CFG_DATA_BITS-1:0]  wr_data,
    output logic [erff_pkg::MAC_BITS-1:0]       station_mac,
    output logic [erff_pkg::IP_BITS-1:0]        station_ip
);
    import erff_pkg::*;

    logic [MAC_BITS-1:0] mac_reg;
    logic [MAC_BITS-1:0] mac_next;
    logic [IP_BITS-1:0]  ip_reg;
    logic [IP_BITS-1:0]  ip_next;

    // register index decode, unused indexes are ignored
    always_comb
    begin
        mac_next = mac_reg;
        ip_next  = ip_reg;
        if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_index))
                CFG_STATION_MAC: mac_next = wr_data[MAC_BITS-1:0];
                CFG_STATION_IP:  ip_next  = wr_data[IP_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_reg <= '0;
            ip_reg  <= '0;
        end
        else
        begin
            mac_reg <= mac_next;
            ip_reg  <= ip_next;
        end
    end

    assign station_mac = mac_reg;
    assign station_ip  = ip_reg;

endmodule

// ===== design/erff_parse.sv =====
// ----------------------------------------------------------------------------
// erff_parse
// Per-frame byte counter and header match flags, one byte per cycle while step is high.
// ----------------------------------------------------------------------------
module erff_parse #(
    parameter int LENGTH_BITS = erff_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [7:0]                    data,
    input  logic                          last,
    input  logic [erff_pkg::MAC_BITS-1:0] station_mac,
    input  logic [erff_pkg::IP_BITS-1:0]  station_ip,
    output erff_pkg::frame_info_t         info_upd,
    output logic [LENGTH_BITS-1:0]        count_upd
);
    import erff_pkg::*;

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

    frame_info_t            info_reg;
    frame_info_t            info_next;
    logic [LENGTH_BITS-1:0] count_reg;
    logic [LENGTH_BITS-1:0] count_next;
    logic [LENGTH_BITS-1:0] pos;
    logic [LENGTH_BITS-1:0] src_off;
    logic [LENGTH_BITS-1:0] ipv4_src_off;
    logic [LENGTH_BITS-1:0] ipv4_dst_off;
    logic [LENGTH_BITS-1:0] arp_off;

    assign pos          = count_reg;
    assign src_off      = pos - LENGTH_BITS'(POS_SRC_MAC);
    assign ipv4_src_off = pos - LENGTH_BITS'(POS_IPV4_SRC);
    assign ipv4_dst_off = pos - LENGTH_BITS'(POS_IPV4_DST);
    assign arp_off      = pos - LENGTH_BITS'(POS_ARP_SPA);

    // header compares for the byte at the current position
    always_comb
    begin
        info_upd = info_reg;
        if (pos < LENGTH_BITS'(POS_SRC_MAC))
        begin
            if (data != mac_octet(station_mac, pos[2:0]))
                info_upd.dest_is_station = 1'b0;
            if (data != BCAST_BYTE)
                info_upd.dest_is_broadcast = 1'b0;
        end
        else if (pos < LENGTH_BITS'(POS_TYPE_HI))
        begin
            if (data != mac_octet(station_mac, src_off[2:0]))
                info_upd.source_is_station = 1'b0;
        end
        else if (pos == LENGTH_BITS'(POS_TYPE_HI))
        begin
            info_upd.ether_type[15:8] = data;
        end
        else if (pos == LENGTH_BITS'(POS_TYPE_LO))
        begin
            info_upd.ether_type[7:0] = data;
        end

        if (pos >= LENGTH_BITS'(POS_IPV4_SRC) && pos < LENGTH_BITS'(POS_IPV4_DST)
            && data != ip_octet(station_ip, ipv4_src_off[1:0]))
            info_upd.ipv4_source_match = 1'b0;
        if (pos >= LENGTH_BITS'(POS_IPV4_DST) && pos < LENGTH_BITS'(POS_IPV4_END)
            && data != ip_octet(station_ip, ipv4_dst_off[1:0]))
            info_upd.ipv4_dest_match = 1'b0;
        if (pos >= LENGTH_BITS'(POS_ARP_SPA) && pos < LENGTH_BITS'(POS_ARP_END)
            && data != ip_octet(station_ip, arp_off[1:0]))
            info_upd.arp_sender_match = 1'b0;
    end

    // saturating byte count
    assign count_upd = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : COUNT_MAX;

    // frame state returns to its cleared value after the final byte
    always_comb
    begin
        info_next  = info_reg;
        count_next = count_reg;
        if (step)
        begin
            if (last)
            begin
                info_next  = FRAME_INFO_CLEAR;
                count_next = '0;
            end
            else
            begin
                info_next  = info_upd;
                count_next = count_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            info_reg  <= FRAME_INFO_CLEAR;
            count_reg <= '0;
        end
        else
        begin
            info_reg  <= info_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/erff_decide.sv =====
// ----------------------------------------------------------------------------
// erff_decide
// Accept or drop verdict from the frame length and header match flags.
// ----------------------------------------------------------------------------
module erff_decide #(
    parameter int LENGTH_BITS = erff_pkg::LENGTH_BITS_DEFAULT
) (
    input  erff_pkg::frame_info_t  info,
    input  logic [LENGTH_BITS-1:0] len,
    output logic                   accept
);
    import erff_pkg::*;

    logic is_ipv4;
    logic is_arp;
    logic ipv4_ok;
    logic arp_ok;

    assign is_ipv4 = (info.ether_type == ETH_IPV4);
    assign is_arp  = (info.ether_type == ETH_ARP);
    assign ipv4_ok = is_ipv4 && info.ipv4_source_match;
    assign arp_ok  = is_arp && info.arp_sender_match;

    // length rules and the ipv4 destination rule first, then the own-source rule
    always_comb
    begin
        if (len < LENGTH_BITS'(MIN_FRAME))
            accept = 1'b0;
        else if (is_ipv4 && (len < LENGTH_BITS'(MIN_IPV4) || info.ipv4_dest_match))
            accept = 1'b0;
        else if (is_arp && len < LENGTH_BITS'(MIN_ARP))
            accept = 1'b0;
        else if (info.source_is_station)
            accept = (info.dest_is_station && (ipv4_ok || arp_ok))
                     || (info.dest_is_broadcast && arp_ok);
        else
            accept = 1'b1;
    end

endmodule

// ===== design/ethernet_receive_frame_filter.sv =====
// ----------------------------------------------------------------------------
// ethernet_receive_frame_filter
// Byte-wide receive filter giving one verdict and length per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one frame byte per transfer (frame_byte, end_of_frame),
//   starting at the destination mac. in_stall is driven by this block.
//   Output channel: one transfer per frame (accept, frame_length), issued
//   after the byte flagged end_of_frame; out_stall is driven by the receiver.
//   Config channel: cfg_index 0 writes the station mac, 1 the station ip;
//   cfg_ready is always high. Write only while no frame is in flight.
// Timing:
//   A byte taken sits in the input register and is then folded into the
//   frame state; a final byte clears the frame state and loads the result
//   register instead, and the verdict transfers from there.
//   One byte per cycle sustained unless in_stall is high: the header compares
//   and the verdict are a single level of logic between input and result registers.
// Reset: clears both station registers, the frame state and all valid flags.
// Stalls: while a result waits, bytes of the next frame keep flowing; only a
//   second final byte waits in the input register, raising in_stall.
// ----------------------------------------------------------------------------
module ethernet_receive_frame_filter #(
    parameter int LENGTH_BITS = erff_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          frame_byte,
    input  logic                                end_of_frame,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                accept,
    output logic [LENGTH_BITS-1:0]              frame_length,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [erff_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [erff_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import erff_pkg::*;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [7:0]             s1_byte_reg;
    logic                   s1_eof_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   accept_reg;
    logic [LENGTH_BITS-1:0] length_reg;
    logic                   out_free;
    logic                   s1_go;
    logic                   in_take;
    logic                   result_load;
    logic [MAC_BITS-1:0]    station_mac;
    logic [IP_BITS-1:0]     station_ip;
    frame_info_t            info_upd;
    logic [LENGTH_BITS-1:0] count_upd;
    logic                   verdict;

    // configuration registers
    assign cfg_ready = 1'b1;

    erff_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (cfg_valid && cfg_ready),
        .wr_index    (cfg_index),
        .wr_data     (cfg_data),
        .station_mac (station_mac),
        .station_ip  (station_ip)
    );

    // flow control: only a final byte needs the result register
    assign out_free    = !out_valid_reg || !out_stall;
    assign s1_go       = s1_valid_reg && (!s1_eof_reg || out_free);
    assign in_stall    = s1_valid_reg && !s1_go;
    assign in_take     = in_valid && !in_stall;
    assign result_load = s1_go && s1_eof_reg;

    // input register
    always_comb
    begin
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= frame_byte;
            s1_eof_reg  <= end_of_frame;
        end
    end

    // frame state and header compares
    erff_parse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_go),
        .data        (s1_byte_reg),
        .last        (s1_eof_reg),
        .station_mac (station_mac),
        .station_ip  (station_ip),
        .info_upd    (info_upd),
        .count_upd   (count_upd)
    );

    // verdict
    erff_decide #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_decide (
        .info   (info_upd),
        .len    (count_upd),
        .accept (verdict)
    );

    // result register
    always_comb
    begin
        if (result_load)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            accept_reg <= verdict;
            length_reg <= count_upd;
        end
    end

    assign out_valid    = out_valid_reg;
    assign accept       = accept_reg;
    assign frame_length = length_reg;

`ifndef SYNTH
    // a final byte leaving the input register always produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_load |=> out_valid)
        else $error("final byte gave no result");

    // the input side only stalls behind a pending final byte and a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_eof_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    // runt frames are never accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_length < LENGTH_BITS'(MIN_FRAME)) |-> !accept)
        else $error("short frame accepted");

    // a result is loaded only from a final byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s1_valid_reg && s1_eof_reg))
        else $error("result without a final byte");
`endif

endmodule
